// ----- src/ust_pkg.sv -----
// ----------------------------------------------------------------------------
// ust_pkg
// Shared widths, constants, types and arithmetic helpers of the UV sphere
// tessellator.
// ----------------------------------------------------------------------------
`default_nettype none

package ust_pkg;

   localparam int COUNT_W   = 9;
   localparam int RADIUS_W  = 16;
   localparam int FIELD_W   = 17;
   localparam int QUO_W     = 33;
   localparam int PHASE_W   = 32;
   localparam int ANGLE_W   = 30;
   localparam int TRIG_W    = 31;
   localparam int INDEX_W   = 2;

   localparam int DEF_MAX_SLICES = 256;
   localparam int DEF_MAX_STACKS = 256;
   localparam int MIN_SLICES     = 3;
   localparam int MIN_STACKS     = 2;

   localparam logic [COUNT_W-1:0]  RST_SLICES = 9'd16;
   localparam logic [COUNT_W-1:0]  RST_STACKS = 9'd8;
   localparam logic [RADIUS_W-1:0] RST_RADIUS = 16'd256;

   // long division: one compare for the integer bit, then 32 fraction bits
   localparam int DIV_STEPS     = 33;
   localparam int DIV_STEPS_STG = 7;
   localparam int DIV_LAT       = 5;
   localparam int TRIG_STG      = 11;
   localparam int TRIG_LAT      = TRIG_STG + 1;

   localparam logic [ANGLE_W-1:0] PI4_Q30 = 30'd843314857;
   localparam logic [TRIG_W-1:0]  ONE30   = 31'h4000_0000;
   localparam logic [FIELD_W-1:0] NRM_ONE = 17'd16384;

   localparam logic [31:0] RCP_42 = 32'((64'd1 << 32) / 64'd42);
   localparam logic [31:0] RCP_20 = 32'((64'd1 << 32) / 64'd20);
   localparam logic [31:0] RCP_6  = 32'((64'd1 << 32) / 64'd6);
   localparam logic [31:0] RCP_56 = 32'((64'd1 << 32) / 64'd56);
   localparam logic [31:0] RCP_30 = 32'((64'd1 << 32) / 64'd30);
   localparam logic [31:0] RCP_12 = 32'((64'd1 << 32) / 64'd12);

   typedef enum logic [INDEX_W-1:0] {
      CSR_SLICE_COUNT,
      CSR_STACK_COUNT,
      CSR_SPHERE_RADIUS
   } ust_csr_type;

   typedef enum logic [1:0] {
      KIND_POSITION,
      KIND_NORMAL,
      KIND_TRI_ACD,
      KIND_TRI_ADB
   } ust_kind_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  stack;
      logic [COUNT_W-1:0]  slice;
      logic [COUNT_W-1:0]  slices;
      logic [COUNT_W-1:0]  stacks;
      logic [RADIUS_W-1:0] radius;
   } ust_pt_type;

   typedef struct packed {
      logic [QUO_W-1:0]   quo;
      logic [COUNT_W-1:0] rem16;
      logic [COUNT_W-1:0] rem31;
      logic [COUNT_W-1:0] rem_fin;
   } ust_quo_type;

   typedef struct packed {
      logic [FIELD_W-1:0]  tex_u;
      logic [FIELD_W-1:0]  tex_v;
      logic [FIELD_W-1:0]  corner_a;
      logic [FIELD_W-1:0]  corner_b;
      logic [FIELD_W-1:0]  corner_c;
      logic [FIELD_W-1:0]  corner_d;
      logic                tri_acd;
      logic                tri_adb;
      logic [RADIUS_W-1:0] radius;
   } ust_side_type;

   typedef struct packed {
      logic [TRIG_W-1:0] cos_mag;
      logic              cos_neg;
      logic [TRIG_W-1:0] sin_mag;
      logic              sin_neg;
   } ust_trig_type;

   typedef struct packed {
      logic [FIELD_W-1:0] pos_x;
      logic [FIELD_W-1:0] pos_y;
      logic [FIELD_W-1:0] pos_z;
      logic [FIELD_W-1:0] nrm_x;
      logic [FIELD_W-1:0] nrm_y;
      logic [FIELD_W-1:0] nrm_z;
      ust_side_type       side;
   } ust_item_type;

   // quotient estimate by reciprocal; low by at most one
   function automatic logic [ANGLE_W-1:0] recip_est(input logic [ANGLE_W-1:0] p,
                                                    input logic [31:0] rcp);
      logic [61:0] prod;
      prod = 62'(p) * 62'(rcp);
      return prod[61:32];
   endfunction

   function automatic logic [ANGLE_W-1:0] recip_fix(input logic [ANGLE_W-1:0] p,
                                                    input logic [ANGLE_W-1:0] est,
                                                    input logic [5:0] d);
      logic [35:0] back;
      logic [35:0] diff;
      back = 36'(est) * 36'(d);
      diff = 36'(p) - back;
      return (diff >= 36'(d)) ? est + 30'd1 : est;
   endfunction

   // (a * b) >> 30 with b at most 1.0 in Q30
   function automatic logic [ANGLE_W-1:0] mul_q30(input logic [ANGLE_W-1:0] a,
                                                  input logic [TRIG_W-1:0] b);
      logic [60:0] prod;
      prod = 61'(a) * 61'(b);
      return prod[59:30];
   endfunction

   // round half away from zero, apply sign, keep 17 bits
   function automatic logic [FIELD_W-1:0] round_q(input logic [63:0] mag,
                                                  input logic neg,
                                                  input int unsigned sh);
      logic [63:0] r;
      r = (mag + (64'd1 << (sh - 1))) >> sh;
      if (neg) r = 64'd0 - r;
      return r[FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/ust_if.sv -----
// ----------------------------------------------------------------------------
// ust_if
// Handshake channels of the UV sphere tessellator: grid point requests,
// results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ust_req_if;
   logic       valid;
   logic       ready;
   logic [8:0] stack_pos;
   logic [8:0] slice_pos;
   modport source (output valid, stack_pos, slice_pos, input ready);
   modport sink   (input valid, stack_pos, slice_pos, output ready);
endinterface

interface ust_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         result_kind;
   logic               last_of_item;
   logic signed [16:0] coord_x;
   logic signed [16:0] coord_y;
   logic signed [16:0] coord_z;
   logic [16:0]        tex_u;
   logic [16:0]        tex_v;
   logic [16:0]        corner_first;
   logic [16:0]        corner_second;
   logic [16:0]        corner_third;
   modport source (output valid, result_kind, last_of_item, coord_x, coord_y, coord_z,
                   tex_u, tex_v, corner_first, corner_second, corner_third,
                   input ready);
   modport sink   (input valid, result_kind, last_of_item, coord_x, coord_y, coord_z,
                   tex_u, tex_v, corner_first, corner_second, corner_third,
                   output ready);
endinterface

interface ust_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- src/ust_div.sv -----
// ----------------------------------------------------------------------------
// ust_div
// Pipelined restoring divider: num * 2^32 / den with num <= den. Gives the
// quotient and the partial remainders needed for rounding at 2^16 and 2^31.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_div import ust_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [COUNT_W-1:0] num,
   input  logic [COUNT_W-1:0] den,
   output ust_quo_type        res
);

   typedef struct packed {
      logic [COUNT_W:0]   rem;
      logic [QUO_W-1:0]   quo;
      logic [COUNT_W-1:0] rem16;
      logic [COUNT_W-1:0] rem31;
      logic [COUNT_W-1:0] dvs;
   } div_stage_type;

   div_stage_type src    [DIV_LAT];
   div_stage_type stg_in [DIV_LAT];
   div_stage_type stg_ff [DIV_LAT];

   for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
      if (g == 0) begin : g_head
         assign src[g] = '{rem: {1'b0, num}, quo: '0, rem16: '0, rem31: '0, dvs: den};
      end else begin : g_body
         assign src[g] = stg_ff[g-1];
      end

      always_comb begin
         div_stage_type w;
         w = src[g];
         for (int j = 0; j < DIV_STEPS_STG; j++) begin
            if (g * DIV_STEPS_STG + j < DIV_STEPS) begin
               if (g * DIV_STEPS_STG + j != 0) w.rem = {w.rem[COUNT_W-1:0], 1'b0};
               if (w.rem >= {1'b0, w.dvs}) begin
                  w.rem = w.rem - {1'b0, w.dvs};
                  w.quo = {w.quo[QUO_W-2:0], 1'b1};
               end else begin
                  w.quo = {w.quo[QUO_W-2:0], 1'b0};
               end
               if (g * DIV_STEPS_STG + j == 16) w.rem16 = w.rem[COUNT_W-1:0];
               if (g * DIV_STEPS_STG + j == 31) w.rem31 = w.rem[COUNT_W-1:0];
            end
         end
         stg_in[g] = w;
      end

      always_ff @(posedge clock) begin
         if (en) stg_ff[g] <= stg_in[g];
      end
   end

   assign res.quo     = stg_ff[DIV_LAT-1].quo;
   assign res.rem16   = stg_ff[DIV_LAT-1].rem16;
   assign res.rem31   = stg_ff[DIV_LAT-1].rem31;
   assign res.rem_fin = stg_ff[DIV_LAT-1].rem[COUNT_W-1:0];

endmodule

`default_nettype wire

// ----- src/ust_trig.sv -----
// ----------------------------------------------------------------------------
// ust_trig
// Pipelined sine and cosine of a 32-bit phase in turns: octant fold,
// Q0.30 radians, Taylor series by Horner steps with constant division
// by reciprocal and one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_trig import ust_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic [PHASE_W-1:0] phase,
   output ust_trig_type       res
);

   typedef struct packed {
      logic [1:0]         quad;
      logic               hi;
      logic [ANGLE_W-1:0] x;
      logic [ANGLE_W-1:0] x2;
      logic [TRIG_W-1:0]  sv;
      logic [TRIG_W-1:0]  cv;
      logic [ANGLE_W-1:0] sp;
      logic [ANGLE_W-1:0] cp;
   } trig_stage_type;

   trig_stage_type st_in [TRIG_STG];
   trig_stage_type st_ff [TRIG_STG];
   ust_trig_type   res_in;
   ust_trig_type   res_ff;

   always_comb begin
      logic [ANGLE_W-1:0] fx;
      logic [59:0]        xp;
      logic [TRIG_W-1:0]  s0;
      logic [TRIG_W-1:0]  c0;
      logic [TRIG_W-1:0]  sa;
      logic [TRIG_W-1:0]  ca;

      // fold into the first octant
      st_in[0]      = '0;
      st_in[0].quad = phase[31:30];
      st_in[0].hi   = phase[29];
      fx = phase[29] ? 30'(ONE30 - 31'(phase[29:0])) : phase[29:0];
      xp = 60'(fx) * 60'(PI4_Q30);
      st_in[0].x = xp[58:29];

      st_in[1]    = st_ff[0];
      st_in[1].x2 = mul_q30(st_ff[0].x, 31'(st_ff[0].x));

      st_in[2]    = st_ff[1];
      st_in[2].sp = st_ff[1].x2;
      st_in[2].cp = st_ff[1].x2;
      st_in[2].sv = 31'(recip_est(st_ff[1].x2, RCP_42));
      st_in[2].cv = 31'(recip_est(st_ff[1].x2, RCP_56));

      st_in[3]    = st_ff[2];
      st_in[3].sv = ONE30 - 31'(recip_fix(st_ff[2].sp, st_ff[2].sv[ANGLE_W-1:0], 6'd42));
      st_in[3].cv = ONE30 - 31'(recip_fix(st_ff[2].cp, st_ff[2].cv[ANGLE_W-1:0], 6'd56));

      st_in[4]    = st_ff[3];
      st_in[4].sp = mul_q30(st_ff[3].x2, st_ff[3].sv);
      st_in[4].cp = mul_q30(st_ff[3].x2, st_ff[3].cv);

      st_in[5]    = st_ff[4];
      st_in[5].sv = 31'(recip_est(st_ff[4].sp, RCP_20));
      st_in[5].cv = 31'(recip_est(st_ff[4].cp, RCP_30));

      st_in[6]    = st_ff[5];
      st_in[6].sv = ONE30 - 31'(recip_fix(st_ff[5].sp, st_ff[5].sv[ANGLE_W-1:0], 6'd20));
      st_in[6].cv = ONE30 - 31'(recip_fix(st_ff[5].cp, st_ff[5].cv[ANGLE_W-1:0], 6'd30));

      st_in[7]    = st_ff[6];
      st_in[7].sp = mul_q30(st_ff[6].x2, st_ff[6].sv);
      st_in[7].cp = mul_q30(st_ff[6].x2, st_ff[6].cv);

      st_in[8]    = st_ff[7];
      st_in[8].sv = 31'(recip_est(st_ff[7].sp, RCP_6));
      st_in[8].cv = 31'(recip_est(st_ff[7].cp, RCP_12));

      st_in[9]    = st_ff[8];
      st_in[9].sv = ONE30 - 31'(recip_fix(st_ff[8].sp, st_ff[8].sv[ANGLE_W-1:0], 6'd6));
      st_in[9].cv = ONE30 - 31'(recip_fix(st_ff[8].cp, st_ff[8].cv[ANGLE_W-1:0], 6'd12));

      // sine closes with x * t; cosine needs one more term
      st_in[10]    = st_ff[9];
      st_in[10].sv = 31'(mul_q30(st_ff[9].x, st_ff[9].sv));
      st_in[10].cp = mul_q30(st_ff[9].x2, st_ff[9].cv);

      s0 = st_ff[10].sv;
      c0 = ONE30 - 31'(st_ff[10].cp >> 1);
      sa = st_ff[10].hi ? c0 : s0;
      ca = st_ff[10].hi ? s0 : c0;
      // odd quadrants swap sine and cosine
      res_in.cos_mag = st_ff[10].quad[0] ? sa : ca;
      res_in.sin_mag = st_ff[10].quad[0] ? ca : sa;
      res_in.cos_neg = st_ff[10].quad[0] ^ st_ff[10].quad[1];
      res_in.sin_neg = st_ff[10].quad[1];
   end

   for (genvar g = 0; g < TRIG_STG; g++) begin : g_stage
      always_ff @(posedge clock) begin
         if (en) st_ff[g] <= st_in[g];
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign res = res_ff;

endmodule

`default_nettype wire

// ----- src/ust_emit.sv -----
// ----------------------------------------------------------------------------
// ust_emit
// Result sequencer: holds one finished grid point and hands out its
// position, normal and up to two triangles, one per cycle while the result port is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module ust_emit import ust_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  ust_item_type  in_item,
   output logic          take,
   ust_rsp_if.source     rsp
);

   logic         hold_ff;
   ust_kind_type kind_ff;
   ust_kind_type kind_in;
   ust_item_type item_ff;
   logic         last;

   always_comb begin
      kind_in = KIND_POSITION;
      last    = 1'b0;
      case (kind_ff)
         KIND_POSITION: begin
            kind_in = KIND_NORMAL;
         end
         KIND_NORMAL: begin
            if (item_ff.side.tri_acd) kind_in = KIND_TRI_ACD;
            else if (item_ff.side.tri_adb) kind_in = KIND_TRI_ADB;
            else last = 1'b1;
         end
         KIND_TRI_ACD: begin
            if (item_ff.side.tri_adb) kind_in = KIND_TRI_ADB;
            else last = 1'b1;
         end
         KIND_TRI_ADB: begin
            last = 1'b1;
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

   assign take = ~hold_ff | (rsp.ready & last);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 1'b0;
         kind_ff <= KIND_POSITION;
      end else if (take) begin
         hold_ff <= in_valid;
         kind_ff <= KIND_POSITION;
      end else if (rsp.ready) begin
         kind_ff <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_valid) item_ff <= in_item;
   end

   always_comb begin
      rsp.valid         = hold_ff;
      rsp.result_kind   = kind_ff;
      rsp.last_of_item  = last;
      rsp.coord_x       = '0;
      rsp.coord_y       = '0;
      rsp.coord_z       = '0;
      rsp.tex_u         = '0;
      rsp.tex_v         = '0;
      rsp.corner_first  = '0;
      rsp.corner_second = '0;
      rsp.corner_third  = '0;
      case (kind_ff)
         KIND_POSITION: begin
            rsp.coord_x = $signed(item_ff.pos_x);
            rsp.coord_y = $signed(item_ff.pos_y);
            rsp.coord_z = $signed(item_ff.pos_z);
            rsp.tex_u   = item_ff.side.tex_u;
            rsp.tex_v   = item_ff.side.tex_v;
         end
         KIND_NORMAL: begin
            rsp.coord_x = $signed(item_ff.nrm_x);
            rsp.coord_y = $signed(item_ff.nrm_y);
            rsp.coord_z = $signed(item_ff.nrm_z);
            rsp.tex_u   = item_ff.side.tex_u;
            rsp.tex_v   = item_ff.side.tex_v;
         end
         KIND_TRI_ACD: begin
            rsp.corner_first  = item_ff.side.corner_a;
            rsp.corner_second = item_ff.side.corner_c;
            rsp.corner_third  = item_ff.side.corner_d;
         end
         KIND_TRI_ADB: begin
            rsp.corner_first  = item_ff.side.corner_a;
            rsp.corner_second = item_ff.side.corner_d;
            rsp.corner_third  = item_ff.side.corner_b;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/uv_sphere_tessellator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_tessellator
// UV sphere mesh generator: one grid point in, its vertex, normal and
// triangles out.
// ----------------------------------------------------------------------------
// A grid point (stack, slice) enters the pipeline in any cycle in which the
// pipe can move. It passes an input register, a five-stage divider for the
// texture coordinates and angle phases, a rounding stage, a twelve-stage
// sine/cosine unit and three multiply/round stages. Each grid point then
// yields two to four results (position, normal, up to two triangles; four
// for an inner cell) through the single result port at one per cycle while
// the port is ready; the next item is taken with the last result of the one
// before, and the pipe stalls while a finished item waits. Register writes
// take effect for items accepted after them.
`default_nettype none

module uv_sphere_tessellator import ust_pkg::*; #(
   parameter int MAX_SLICES = DEF_MAX_SLICES,
   parameter int MAX_STACKS = DEF_MAX_STACKS
) (
   input  logic       clock,
   input  logic       reset,
   ust_req_if.sink    req_bus,
   ust_rsp_if.source  rsp_bus,
   ust_csr_if.sink    csr_bus
);

   typedef struct packed {
      ust_side_type       side;
      logic [ANGLE_W-1:0] m;
      logic [TRIG_W-1:0]  cth_mag;
      logic [TRIG_W-1:0]  sth_mag;
      logic               x_neg;
      logic               z_neg;
      logic               y_neg;
      logic [61:0]        nx_prod;
      logic [61:0]        nz_prod;
      logic [46:0]        py_prod;
      logic [FIELD_W-1:0] nrm_y;
   } mul1_type;

   typedef struct packed {
      ust_side_type       side;
      logic               x_neg;
      logic               z_neg;
      logic [60:0]        px_prod;
      logic [60:0]        pz_prod;
      logic [FIELD_W-1:0] pos_y;
      logic [FIELD_W-1:0] nrm_x;
      logic [FIELD_W-1:0] nrm_y;
      logic [FIELD_W-1:0] nrm_z;
   } mul2_type;

   logic [COUNT_W-1:0]  slices_ff;
   logic [COUNT_W-1:0]  stacks_ff;
   logic [RADIUS_W-1:0] radius_ff;

   logic adv;
   logic take;

   ust_pt_type   pt_in, pt_ff;
   logic         v0_ff;
   ust_pt_type   dpt_ff [DIV_LAT];
   logic         dv_ff  [DIV_LAT];
   ust_quo_type  quo_i, quo_s;

   ust_side_type       rside_in, rside_ff;
   logic [PHASE_W-1:0] pth_in, pth_ff, pph_in, pph_ff;
   logic               rv_ff;

   ust_side_type tside_ff [TRIG_LAT];
   logic         tv_ff    [TRIG_LAT];
   ust_trig_type trig_th, trig_ph;

   mul1_type     m1_in, m1_ff;
   logic         m1_v_ff;
   mul2_type     m2_in, m2_ff;
   logic         m2_v_ff;
   ust_item_type p3_in, p3_ff;
   logic         p3_v_ff;

   // ---------------------------------------------------------------- registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slices_ff <= RST_SLICES;
         stacks_ff <= RST_STACKS;
         radius_ff <= RST_RADIUS;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_SLICE_COUNT:   slices_ff <= csr_bus.data[COUNT_W-1:0];
            CSR_STACK_COUNT:   stacks_ff <= csr_bus.data[COUNT_W-1:0];
            CSR_SPHERE_RADIUS: radius_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   // whole pipe moves together; it only waits when the last stage is blocked
   assign adv           = ~p3_v_ff | take;
   assign req_bus.ready = adv;

   // -------------------------------------------------------------- input stage
   always_comb begin
      logic [COUNT_W-1:0] sl;
      logic [COUNT_W-1:0] st;
      if (slices_ff < COUNT_W'(MIN_SLICES)) sl = COUNT_W'(MIN_SLICES);
      else if (32'(slices_ff) > 32'(MAX_SLICES)) sl = COUNT_W'(MAX_SLICES);
      else sl = slices_ff;
      if (stacks_ff < COUNT_W'(MIN_STACKS)) st = COUNT_W'(MIN_STACKS);
      else if (32'(stacks_ff) > 32'(MAX_STACKS)) st = COUNT_W'(MAX_STACKS);
      else st = stacks_ff;
      pt_in.slices = sl;
      pt_in.stacks = st;
      pt_in.stack  = (req_bus.stack_pos > st) ? st : req_bus.stack_pos;
      pt_in.slice  = (req_bus.slice_pos > sl) ? sl : req_bus.slice_pos;
      pt_in.radius = radius_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (adv) v0_ff <= req_bus.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) pt_ff <= pt_in;
   end

   // ------------------------------------------------------------------ divider
   ust_div u_div_slice (
      .clock (clock),
      .en    (adv),
      .num   (pt_ff.slice),
      .den   (pt_ff.slices),
      .res   (quo_i)
   );

   ust_div u_div_stack (
      .clock (clock),
      .en    (adv),
      .num   (pt_ff.stack),
      .den   (pt_ff.stacks),
      .res   (quo_s)
   );

   for (genvar g = 0; g < DIV_LAT; g++) begin : g_div_side
      if (g == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) dv_ff[g] <= 1'b0;
            else if (adv) dv_ff[g] <= v0_ff;
         end
         always_ff @(posedge clock) begin
            if (adv) dpt_ff[g] <= pt_ff;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) dv_ff[g] <= 1'b0;
            else if (adv) dv_ff[g] <= dv_ff[g-1];
         end
         always_ff @(posedge clock) begin
            if (adv) dpt_ff[g] <= dpt_ff[g-1];
         end
      end
   end

   // ----------------------------------------------------------------- rounding
   always_comb begin
      ust_pt_type         pt;
      logic [COUNT_W:0]   hs_i;
      logic [COUNT_W:0]   hs_s;
      logic               up_pth, up_tu, up_pph, up_tv;
      logic [19:0]        a_full;
      logic               in_grid;
      pt   = dpt_ff[DIV_LAT-1];
      hs_i = {2'b0, pt.slices[COUNT_W-1:1]};
      hs_s = {2'b0, pt.stacks[COUNT_W-1:1]};
      up_pth = ({1'b0, quo_i.rem_fin} + hs_i) >= {1'b0, pt.slices};
      up_tu  = ({1'b0, quo_i.rem16}   + hs_i) >= {1'b0, pt.slices};
      up_pph = ({1'b0, quo_s.rem31}   + hs_s) >= {1'b0, pt.stacks};
      up_tv  = ({1'b0, quo_s.rem16}   + hs_s) >= {1'b0, pt.stacks};
      pth_in = quo_i.quo[31:0] + PHASE_W'(up_pth);
      pph_in = quo_s.quo[32:1] + PHASE_W'(up_pph);
      rside_in.tex_u = quo_i.quo[32:16] + FIELD_W'(up_tu);
      rside_in.tex_v = quo_s.quo[32:16] + FIELD_W'(up_tv);
      a_full = 20'(pt.stack) * (20'(pt.slices) + 20'd1) + 20'(pt.slice);
      rside_in.corner_a = a_full[FIELD_W-1:0];
      rside_in.corner_b = a_full[FIELD_W-1:0] + 17'd1;
      rside_in.corner_c = a_full[FIELD_W-1:0] + 17'(pt.slices) + 17'd1;
      rside_in.corner_d = a_full[FIELD_W-1:0] + 17'(pt.slices) + 17'd2;
      in_grid = (pt.stack < pt.stacks) && (pt.slice < pt.slices);
      // no a-c-d triangle next to the bottom pole, no a-d-b one at the top pole
      rside_in.tri_acd = in_grid && ((10'(pt.stack) + 10'd1) != 10'(pt.stacks));
      rside_in.tri_adb = in_grid && (pt.stack != '0);
      rside_in.radius  = pt.radius;
   end

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else if (adv) rv_ff <= dv_ff[DIV_LAT-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pth_ff   <= pth_in;
         pph_ff   <= pph_in;
         rside_ff <= rside_in;
      end
   end

   // --------------------------------------------------------------------- trig
   ust_trig u_trig_lon (
      .clock (clock),
      .en    (adv),
      .phase (pth_ff),
      .res   (trig_th)
   );

   ust_trig u_trig_lat (
      .clock (clock),
      .en    (adv),
      .phase (pph_ff),
      .res   (trig_ph)
   );

   for (genvar g = 0; g < TRIG_LAT; g++) begin : g_trig_side
      if (g == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) tv_ff[g] <= 1'b0;
            else if (adv) tv_ff[g] <= rv_ff;
         end
         always_ff @(posedge clock) begin
            if (adv) tside_ff[g] <= rside_ff;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) tv_ff[g] <= 1'b0;
            else if (adv) tv_ff[g] <= tv_ff[g-1];
         end
         always_ff @(posedge clock) begin
            if (adv) tside_ff[g] <= tside_ff[g-1];
         end
      end
   end

   // ---------------------------------------------------------------- products
   always_comb begin
      logic [46:0] mp;
      mp = 47'(tside_ff[TRIG_LAT-1].radius) * 47'(trig_ph.sin_mag);
      m1_in.side    = tside_ff[TRIG_LAT-1];
      m1_in.m       = mp[45:16];
      m1_in.cth_mag = trig_th.cos_mag;
      m1_in.sth_mag = trig_th.sin_mag;
      m1_in.x_neg   = trig_ph.sin_neg != trig_th.cos_neg;
      m1_in.z_neg   = trig_ph.sin_neg == trig_th.sin_neg;
      m1_in.y_neg   = trig_ph.cos_neg;
      m1_in.nx_prod = 62'(trig_ph.sin_mag) * 62'(trig_th.cos_mag);
      m1_in.nz_prod = 62'(trig_ph.sin_mag) * 62'(trig_th.sin_mag);
      m1_in.py_prod = 47'(tside_ff[TRIG_LAT-1].radius) * 47'(trig_ph.cos_mag);
      m1_in.nrm_y   = round_q(64'(trig_ph.cos_mag), trig_ph.cos_neg, 16);
   end

   always_comb begin
      m2_in.side    = m1_ff.side;
      m2_in.x_neg   = m1_ff.x_neg;
      m2_in.z_neg   = m1_ff.z_neg;
      m2_in.px_prod = 61'(m1_ff.m) * 61'(m1_ff.cth_mag);
      m2_in.pz_prod = 61'(m1_ff.m) * 61'(m1_ff.sth_mag);
      m2_in.pos_y   = round_q(64'(m1_ff.py_prod), m1_ff.y_neg, 30);
      if (m1_ff.side.radius == '0) begin
         // degenerate sphere: fixed upward normal
         m2_in.nrm_x = '0;
         m2_in.nrm_y = NRM_ONE;
         m2_in.nrm_z = '0;
      end else begin
         m2_in.nrm_x = round_q(64'(m1_ff.nx_prod), m1_ff.x_neg, 46);
         m2_in.nrm_y = m1_ff.nrm_y;
         m2_in.nrm_z = round_q(64'(m1_ff.nz_prod), m1_ff.z_neg, 46);
      end
   end

   always_comb begin
      p3_in.side  = m2_ff.side;
      p3_in.pos_x = round_q(64'(m2_ff.px_prod), m2_ff.x_neg, 44);
      p3_in.pos_y = m2_ff.pos_y;
      p3_in.pos_z = round_q(64'(m2_ff.pz_prod), m2_ff.z_neg, 44);
      p3_in.nrm_x = m2_ff.nrm_x;
      p3_in.nrm_y = m2_ff.nrm_y;
      p3_in.nrm_z = m2_ff.nrm_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= tv_ff[TRIG_LAT-1];
         m2_v_ff <= m1_v_ff;
         p3_v_ff <= m2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         p3_ff <= p3_in;
      end
   end

   // ----------------------------------------------------------------- results
   ust_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (p3_v_ff),
      .in_item  (p3_ff),
      .take     (take),
      .rsp      (rsp_bus)
   );

endmodule

`default_nettype wire
